@@ design/positional_ordered_list_core_defines.svh @@
`ifndef POSITIONAL_ORDERED_LIST_CORE_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define POL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pol check failed");

// next-cycle implication
`define POL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pol check failed");

`endif

@@ design/pol_pkg.sv @@
`default_nettype none

package pol_pkg;

    localparam int POL_CAPACITY = 64;
    localparam int OP_W         = 3;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 7;
    localparam int STATUS_W     = 3;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_FIND   = 3'd3,
        OP_LIST   = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] item_value;
        logic [POS_W-1:0]          item_position;
        logic [POS_W-1:0]          list_length;
        logic                      last;
    } out_word_t;

    typedef enum logic [2:0] {
        RD_TAIL = 3'd0,
        RD_POS  = 3'd1,
        RD_ZERO = 3'd2,
        RD_DEC  = 3'd3,
        RD_INC  = 3'd4
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE  = 3'd0,
        WR_TAIL  = 3'd1,
        WR_INC   = 3'd2,
        WR_DEC   = 3'd3,
        WR_PLACE = 3'd4
    } wr_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2
    } cnt_sel_t;

    typedef struct packed {
        logic     load;
        rd_sel_t  rd_sel;
        wr_sel_t  wr_sel;
        cnt_sel_t cnt_sel;
        logic     emit;
        status_t  emit_status;
        logic     emit_item;
        logic     emit_last;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic ins_bad;
        logic ins_tail;
        logic del_bad;
        logic del_tail;
        logic up_end;
        logic seq_end;
        logic match;
    } dp_flags_t;

endpackage

`default_nettype wire

@@ design/positional_ordered_list_core.sv @@
// channel  | direction | handshake               | word
// ---------+-----------+-------------------------+-------------------------
// request  | in        | start & !busy           | req    (op/value/position)
// result   | out       | strobe, one cycle only  | result (status/item/len/last)
//
// Append, every error, insert at the tail and delete of the last element: result
// the cycle after the word is taken. Insert at N: N..length moved one RAM entry
// a cycle, then the value is written. Delete at N: N+1..length moved down one
// entry a cycle. Find scans from the head to a match or the end, list sends every
// entry, one a cycle, set by the one write and one registered read port of the RAM.
// busy is high while an op is in flight; reset empties the list; no result stalls.
`default_nettype none

module positional_ordered_list_core #(
    parameter int CAPACITY = pol_pkg::POL_CAPACITY
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  pol_pkg::in_word_t  req,
    output logic               strobe,
    output pol_pkg::out_word_t result
);

    import pol_pkg::*;

    dp_cmd_t   cmd;
    dp_flags_t flags;

    pol_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (req.op),
        .flags (flags),
        .busy  (busy),
        .cmd   (cmd)
    );

    pol_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .flags  (flags),
        .strobe (strobe),
        .result (result)
    );

endmodule

`default_nettype wire

@@ design/pol_ram.sv @@
`default_nettype none

module pol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ design/pol_ctrl.sv @@
`default_nettype none

module pol_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [pol_pkg::OP_W-1:0] op,
    input  pol_pkg::dp_flags_t       flags,
    output logic                     busy,
    output pol_pkg::dp_cmd_t         cmd
);

    import pol_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_UP    = 6'b000010,
        S_PLACE = 6'b000100,
        S_DOWN  = 6'b001000,
        S_SCAN  = 6'b010000,
        S_LIST  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.rd_sel      = RD_INC;
        cmd.wr_sel      = WR_NONE;
        cmd.cnt_sel     = CNT_HOLD;
        cmd.emit_status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load      = 1'b1;
                    cmd.emit_last = 1'b1;
                    unique case (op)
                        OP_APPEND:
                        begin
                            cmd.emit = 1'b1;
                            if (flags.full)
                            begin
                                cmd.emit_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.wr_sel  = WR_TAIL;
                                cmd.cnt_sel = CNT_INC;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (flags.ins_bad)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = ST_RANGE;
                            end
                            else if (flags.full)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = ST_FULL;
                            end
                            else if (flags.ins_tail)
                            begin
                                cmd.emit    = 1'b1;
                                cmd.wr_sel  = WR_TAIL;
                                cmd.cnt_sel = CNT_INC;
                            end
                            else
                            begin
                                cmd.rd_sel = RD_TAIL;
                                state_next = S_UP;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (flags.empty)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = ST_EMPTY;
                            end
                            else if (flags.del_bad)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = ST_RANGE;
                            end
                            else if (flags.del_tail)
                            begin
                                cmd.emit    = 1'b1;
                                cmd.cnt_sel = CNT_DEC;
                            end
                            else
                            begin
                                cmd.rd_sel = RD_POS;
                                state_next = S_DOWN;
                            end
                        end
                        OP_FIND, OP_LIST:
                        begin
                            if (flags.empty)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.rd_sel = RD_ZERO;
                                state_next = (op == OP_FIND) ? S_SCAN : S_LIST;
                            end
                        end
                        default:
                        begin
                            cmd.load      = 1'b0;
                            cmd.emit_last = 1'b0;
                        end
                    endcase
                end
            end
            S_UP:
            begin
                cmd.wr_sel = WR_INC;
                cmd.rd_sel = RD_DEC;
                if (flags.up_end)
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                cmd.wr_sel    = WR_PLACE;
                cmd.cnt_sel   = CNT_INC;
                cmd.emit      = 1'b1;
                cmd.emit_last = 1'b1;
                state_next    = S_IDLE;
            end
            S_DOWN:
            begin
                cmd.wr_sel = WR_DEC;
                if (flags.seq_end)
                begin
                    cmd.cnt_sel   = CNT_DEC;
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (flags.match)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_item = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (flags.seq_end)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_NOTFOUND;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_LIST:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_item = 1'b1;
                cmd.emit_last = flags.seq_end;
                if (flags.seq_end)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/pol_datapath.sv @@
`default_nettype none

module pol_datapath #(
    parameter int CAPACITY = pol_pkg::POL_CAPACITY
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pol_pkg::in_word_t  req,
    input  pol_pkg::dp_cmd_t   cmd,
    output pol_pkg::dp_flags_t flags,
    output logic               strobe,
    output pol_pkg::out_word_t result
);

    import pol_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic [AW-1:0]             rd_idx_reg;
    logic [AW-1:0]             pos_idx_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic                      strobe_reg;
    out_word_t                 result_reg;

    logic [AW-1:0]             rd_addr;
    logic [VALUE_W-1:0]        rd_data;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [VALUE_W-1:0]        wr_data;
    logic [XW-1:0]             pos_x;
    logic [XW-1:0]             count_x;

    assign pos_x   = XW'(req.position);
    assign count_x = XW'(count_reg);

    always_comb
    begin
        flags.full     = (count_reg == CW'(CAPACITY));
        flags.empty    = (count_reg == '0);
        flags.ins_bad  = (pos_x == '0) || (pos_x > count_x + XW'(1));
        flags.ins_tail = (pos_x == count_x + XW'(1));
        flags.del_bad  = (pos_x == '0) || (pos_x > count_x);
        flags.del_tail = (pos_x == count_x);
        flags.up_end   = (rd_idx_reg == pos_idx_reg);
        flags.seq_end  = (rd_idx_reg == AW'(count_reg - CW'(1)));
        flags.match    = (rd_data == value_reg);
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_TAIL: rd_addr = AW'(count_reg - CW'(1));
            RD_POS:  rd_addr = AW'(pos_x);
            RD_ZERO: rd_addr = '0;
            RD_DEC:  rd_addr = rd_idx_reg - AW'(1);
            default: rd_addr = rd_idx_reg + AW'(1);
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = rd_idx_reg;
        wr_data = rd_data;
        case (cmd.wr_sel)
            WR_TAIL:
            begin
                wr_addr = AW'(count_reg);
                wr_data = req.value;
            end
            WR_INC:
            begin
                wr_addr = rd_idx_reg + AW'(1);
            end
            WR_DEC:
            begin
                wr_addr = rd_idx_reg - AW'(1);
            end
            WR_PLACE:
            begin
                wr_addr = pos_idx_reg;
                wr_data = value_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.cnt_sel)
            CNT_INC: count_next = count_reg + CW'(1);
            CNT_DEC: count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    pol_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            strobe_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_addr;
        if (cmd.load)
        begin
            value_reg   <= req.value;
            pos_idx_reg <= AW'(pos_x - XW'(1));
        end
        if (cmd.emit)
        begin
            result_reg.status        <= cmd.emit_status;
            result_reg.item_value    <= cmd.emit_item ? rd_data : '0;
            result_reg.item_position <= cmd.emit_item ?
                                        POS_W'(XW'(rd_idx_reg) + XW'(1)) : '0;
            result_reg.list_length   <= POS_W'(count_next);
            result_reg.last          <= cmd.emit_last;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

@@ design/pol_checker.sv @@
`default_nettype none

`include "positional_ordered_list_core_defines.svh"

module pol_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input pol_pkg::in_word_t  req,
    input logic               strobe,
    input pol_pkg::out_word_t result
);

    import pol_pkg::*;

    `POL_ASSERT_SAME(a_last_frees, strobe && result.last, !busy)
    `POL_ASSERT_SAME(a_more_busy, strobe && !result.last, busy)
    `POL_ASSERT_NEXT(a_list_burst, strobe && !result.last, strobe)
    `POL_ASSERT_NEXT(a_append_one, start && !busy && req.op == OP_APPEND, strobe && result.last)

endmodule

bind positional_ordered_list_core pol_checker u_pol_checker (.*);

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import pol_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_ITEMS = 150;
    localparam int REPORT_MAX   = 10;
    localparam int TAIL_CYCLES  = 2 * POL_CAPACITY + 16;
    localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

    class list_scoreboard;
        logic signed [VALUE_W-1:0] contents[$];
        out_word_t                 expected_q[$];
        int                        words_checked;
        int                        errors;

        function void push_word(status_t st, logic signed [VALUE_W-1:0] v, int pos, bit fin);
            out_word_t w;
            w.status        = st;
            w.item_value    = v;
            w.item_position = POS_W'(pos);
            w.list_length   = POS_W'(contents.size());
            w.last          = fin;
            expected_q.push_back(w);
        endfunction

        function void note_request(in_word_t w);
            int n;
            int i;
            int hit;
            n   = contents.size();
            hit = 0;
            case (w.op)
                OP_APPEND:
                    if (n >= POL_CAPACITY)
                        push_word(ST_FULL, 0, 0, 1);
                    else
                    begin
                        contents.push_back(w.value);
                        push_word(ST_OK, 0, 0, 1);
                    end
                OP_INSERT:
                    if (w.position < 1 || w.position > n + 1)
                        push_word(ST_RANGE, 0, 0, 1);
                    else if (n >= POL_CAPACITY)
                        push_word(ST_FULL, 0, 0, 1);
                    else
                    begin
                        contents.insert(int'(w.position) - 1, w.value);
                        push_word(ST_OK, 0, 0, 1);
                    end
                OP_DELETE:
                    if (n == 0)
                        push_word(ST_EMPTY, 0, 0, 1);
                    else if (w.position < 1 || w.position > n)
                        push_word(ST_RANGE, 0, 0, 1);
                    else
                    begin
                        contents.delete(int'(w.position) - 1);
                        push_word(ST_OK, 0, 0, 1);
                    end
                OP_FIND:
                    if (n == 0)
                        push_word(ST_EMPTY, 0, 0, 1);
                    else
                    begin
                        for (i = 0; i < n && hit == 0; i++)
                            if (contents[i] == w.value)
                                hit = i + 1;
                        if (hit != 0)
                            push_word(ST_OK, w.value, hit, 1);
                        else
                            push_word(ST_NOTFOUND, 0, 0, 1);
                    end
                OP_LIST:
                    if (n == 0)
                        push_word(ST_EMPTY, 0, 0, 1);
                    else
                        for (i = 0; i < n; i++)
                            push_word(ST_OK, contents[i], i + 1, i == n - 1);
                default:
                    ;
            endcase
        endfunction

        function void check_word(out_word_t got);
            out_word_t want;
            bit        bad;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected result word: st %0d val %0d pos %0d len %0d last %0b",
                             got.status, got.item_value, got.item_position, got.list_length,
                             got.last);
                return;
            end
            want = expected_q.pop_front();
            words_checked++;
            bad = (got.status !== want.status) || (got.item_value !== want.item_value) ||
                  (got.item_position !== want.item_position) ||
                  (got.list_length !== want.list_length) || (got.last !== want.last);
            if (bad)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                begin
                    $write("word %0d: want st %0d val %0d pos %0d len %0d last %0b, ",
                           words_checked, want.status, want.item_value, want.item_position,
                           want.list_length, want.last);
                    $display("got st %0d val %0d pos %0d len %0d last %0b",
                             got.status, got.item_value, got.item_position, got.list_length,
                             got.last);
                end
            end
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    in_word_t       req = '0;
    logic           strobe;
    out_word_t      result;
    int             cycle_count = 0;
    int             op_seen[8];
    bit             no_gaps = 1'b0;
    bit             full_seen = 1'b0;
    list_scoreboard sb = new();

    positional_ordered_list_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .strobe (strobe),
        .result (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && strobe)
            sb.check_word(result);
    end

    task automatic issue(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] value,
                         input int pos);
        in_word_t w;
        int       gap;
        w.op       = op;
        w.value    = value;
        w.position = POS_W'(pos);
        req   <= w;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(w);
        op_seen[w.op]++;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_q.size() != 0);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3 && sb.contents.size() > 0)
            return sb.contents[$urandom_range(0, sb.contents.size() - 1)];
        if (r < 5)
            return $urandom_range(0, 7) - 4;
        if (r == 5)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh7fffffff;
                1: return 32'sh80000000;
                2: return '0;
                default: return '1;
            endcase
        end
        return $urandom();
    endfunction

    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        int n;
        int r;
        int len;
        int growing;
        int ins_pos;
        int del_pos;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // empty-list corner cases, then range edges on a short list and unused opcodes
        issue(OP_LIST, 0, 0);
        issue(OP_FIND, 5, 0);
        issue(OP_DELETE, 0, 1);
        issue(OP_INSERT, 1, 0);
        issue(OP_INSERT, 1, 2);
        issue(OP_INSERT, 32'sh7fffffff, 1);
        issue(OP_APPEND, 32'sh80000000, 0);
        issue(OP_APPEND, 0, 127);
        issue(OP_APPEND, -1, 0);
        issue(OP_INSERT, 5, 1);
        issue(OP_INSERT, 5, 3);
        issue(OP_INSERT, 32'sh55555555, 7);
        issue(OP_INSERT, 9, 127);
        issue(OP_FIND, 5, 0);
        issue(OP_FIND, 32'shaaaaaaaa, 0);
        issue(OP_FIND, 32'sh55555555, 0);
        issue(OP_LIST, 0, 0);
        issue(OP_DELETE, 0, 0);
        issue(OP_DELETE, 0, 8);
        issue(OP_DELETE, 0, 3);
        issue(OP_DELETE, 0, 6);
        issue(OP_DELETE, 0, 1);
        issue(OP_SPARE_LO, 0, 1);
        issue(OP_SPARE_MID, -1, 127);
        issue(OP_SPARE_HI, 32'sh7fffffff, 64);
        issue(OP_LIST, 0, 0);
        wait_drained();

        growing = 1;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 30 == 0)
                no_gaps = ((n / 30) % 2 == 1);
            len = sb.contents.size();
            if (len == POL_CAPACITY && !full_seen)
            begin
                full_seen = 1'b1;
                wait_drained();
                issue(OP_APPEND, pick_value(), 0);
                issue(OP_INSERT, pick_value(), 1);
                issue(OP_INSERT, pick_value(), POL_CAPACITY + 2);
                issue(OP_LIST, 0, 0);
                growing = 0;
            end
            if (len == POL_CAPACITY && $urandom_range(0, 3) == 0)
                growing = 0;
            if (len <= 2)
                growing = 1;
            if ($urandom_range(0, 29) == 0)
                wait_drained();
            r       = $urandom_range(0, 99);
            ins_pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                  : $urandom_range(1, len + 1);
            del_pos = ($urandom_range(0, 9) == 0 || len == 0) ? $urandom_range(0, 127)
                                                              : $urandom_range(1, len);
            if (r < (growing ? 45 : 10))
                issue(OP_APPEND, pick_value(), $urandom_range(0, 127));
            else if (r < (growing ? 85 : 20))
                issue(OP_INSERT, pick_value(), ins_pos);
            else if (r < (growing ? 90 : 70))
                issue(OP_DELETE, pick_value(), del_pos);
            else if (r < (growing ? 94 : 82))
                issue(OP_FIND, pick_value(), $urandom_range(0, 127));
            else if (r < (growing ? 96 : 90))
                issue(OP_LIST, pick_value(), $urandom_range(0, 127));
            else
                issue(OP_W'($urandom_range(OP_APPEND, OP_SPARE_HI)), $urandom(),
                      $urandom_range(0, 127));
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        sb.errors += sb.expected_q.size();

        $write("words sent: %0d append, %0d insert, %0d delete, ",
               op_seen[OP_APPEND], op_seen[OP_INSERT], op_seen[OP_DELETE]);
        $display("%0d find, %0d list, %0d unused op", op_seen[OP_FIND], op_seen[OP_LIST],
                 op_seen[OP_SPARE_LO] + op_seen[OP_SPARE_MID] + op_seen[OP_SPARE_HI]);
        $display("%0d result words checked, full list reached: %0d, errors: %0d",
                 sb.words_checked, full_seen, sb.errors);
        if (sb.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/pol_pkg.sv
design/pol_ram.sv
design/pol_ctrl.sv
design/pol_datapath.sv
design/positional_ordered_list_core.sv
design/pol_checker.sv
test/testbench.sv
